/* src/c_token_classifier_top_assert.svh */
// ----------------------------------------------------------------------------
// c_token_classifier_top_assert.svh
// assertion macros shared by the token classifier modules
// ----------------------------------------------------------------------------
`ifndef C_TOKEN_CLASSIFIER_TOP_ASSERT_SVH
`define C_TOKEN_CLASSIFIER_TOP_ASSERT_SVH

// condition holds at every edge out of reset
`define CTC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CTC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* src/ctc_pkg.sv */
// ----------------------------------------------------------------------------
// ctc_pkg
// types, constants and keyword table of the c token classifier
// ----------------------------------------------------------------------------
package ctc_pkg;

  localparam int MAX_TOKEN_BYTES = 8;
  localparam int KEYWORD_COUNT   = 32;
  localparam int BYTE_W          = 8;
  localparam int TEXT_W          = 64;
  localparam int LEN_W           = 4;
  localparam int KWI_W           = 5;
  localparam int KIND_W          = 3;
  localparam int BIDX_W          = $clog2(TEXT_W / BYTE_W);
  localparam int QUEUE_DEPTH     = 4;

  // character codes
  localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_EQUAL  = 8'h3D;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
  localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
  localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;

  typedef enum logic [KIND_W-1:0] {
    KIND_OPERATOR   = 3'd0,
    KIND_SEPARATOR  = 3'd1,
    KIND_NUMBER     = 3'd2,
    KIND_KEYWORD    = 3'd3,
    KIND_IDENTIFIER = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_NUMBER = 2'd1,
    MODE_WORD   = 2'd2
  } mode_t;

  // one queue entry: a finished run and/or a one-byte token
  typedef struct packed {
    logic                has_flush;
    logic                flush_word;
    logic [TEXT_W-1:0]   flush_text;
    logic [LEN_W-1:0]    flush_len;
    logic                flush_trunc;
    logic                has_char;
    kind_t               char_kind;
    logic [BYTE_W-1:0]   char_byte;
  } rec_t;

  typedef struct packed {
    logic             hit;
    logic [KWI_W-1:0] idx;
  } kw_hit_t;

  // keyword names, string literals right aligned
  localparam logic [TEXT_W-1:0] KW_NAME [KEYWORD_COUNT] = '{
    64'("auto"),     64'("break"),    64'("case"),     64'("char"),
    64'("const"),    64'("continue"), 64'("default"),  64'("do"),
    64'("double"),   64'("else"),     64'("enum"),     64'("extern"),
    64'("float"),    64'("for"),      64'("goto"),     64'("if"),
    64'("int"),      64'("long"),     64'("register"), 64'("return"),
    64'("short"),    64'("signed"),   64'("sizeof"),   64'("static"),
    64'("struct"),   64'("switch"),   64'("typedef"),  64'("union"),
    64'("unsigned"), 64'("void"),     64'("volatile"), 64'("while")
  };

  function automatic logic is_digit(input logic [BYTE_W-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [BYTE_W-1:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_operator(input logic [BYTE_W-1:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
           (c == CH_SLASH) || (c == CH_EQUAL);
  endfunction

  function automatic logic is_separator(input logic [BYTE_W-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_SEMI) ||
           (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_LBRACE) ||
           (c == CH_RBRACE) || (c == CH_LBRACK) || (c == CH_RBRACK) ||
           (c == CH_COMMA);
  endfunction

  // number of bytes in a keyword name
  function automatic logic [LEN_W-1:0] kw_len(input int unsigned idx);
    logic [TEXT_W-1:0] s;
    logic [LEN_W-1:0]  n;
    s = KW_NAME[idx];
    n = '0;
    for (int j = 0; j < TEXT_W / BYTE_W; j++) begin
      if (s[BYTE_W*j +: BYTE_W] != 8'h00) n = n + 1'b1;
    end
    return n;
  endfunction

  // keyword packed first byte low, as the token buffer holds it
  function automatic logic [TEXT_W-1:0] kw_text(input int unsigned idx);
    logic [TEXT_W-1:0] s;
    logic [TEXT_W-1:0] t;
    int                n;
    s = KW_NAME[idx];
    t = '0;
    n = int'(kw_len(idx));
    for (int j = 0; j < TEXT_W / BYTE_W; j++) begin
      if (j < n) t[BYTE_W*j +: BYTE_W] = s[BYTE_W*(n-1-j) +: BYTE_W];
    end
    return t;
  endfunction

  // parallel compare against all keywords, lowest index wins
  function automatic kw_hit_t kw_match(input logic [TEXT_W-1:0] text,
                                       input logic [LEN_W-1:0] len,
                                       input logic trunc);
    kw_hit_t r;
    r = '0;
    for (int i = KEYWORD_COUNT - 1; i >= 0; i--) begin
      if (!trunc && (len == kw_len(i)) && (text == kw_text(i))) begin
        r.hit = 1'b1;
        r.idx = KWI_W'(i);
      end
    end
    return r;
  endfunction

endpackage

/* src/ctc_fifo.sv */
// ----------------------------------------------------------------------------
// ctc_fifo
// small register queue between scanner front and token back end
// ----------------------------------------------------------------------------
module ctc_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  ctc_pkg::rec_t  wr_data,
  output logic           full,
  input  logic           rd_en,
  output ctc_pkg::rec_t  rd_data,
  output logic           empty
);
  import ctc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  rec_t             entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = entry_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* src/ctc_front.sv */
// ----------------------------------------------------------------------------
// ctc_front
// scanner front: takes bytes, tracks the current run, queues token work
// ----------------------------------------------------------------------------
`include "c_token_classifier_top_assert.svh"

module ctc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ctc_pkg::BYTE_W-1:0]  in_char_byte,
  input  logic                        in_end_of_input,
  input  logic                        push,
  output logic                        full,
  output logic                        q_push,
  output ctc_pkg::rec_t               q_wdata,
  input  logic                        q_full
);
  import ctc_pkg::*;

  mode_t              mode_r, mode_nxt;
  logic [TEXT_W-1:0]  buf_r, buf_nxt;
  logic [LEN_W-1:0]   cnt_r, cnt_nxt;
  logic               ovf_r, ovf_nxt;
  logic               accept;
  logic               dig, alpha, cont, flush, fresh;
  rec_t               rec;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign dig    = is_digit(in_char_byte);
  assign alpha  = is_alpha(in_char_byte);

  // run tracking and queue entry build
  always_comb begin
    mode_nxt = mode_r;
    buf_nxt  = buf_r;
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    rec      = '0;
    cont     = 1'b0;
    flush    = 1'b0;
    fresh    = 1'b0;

    unique case (mode_r)
      MODE_NUMBER: cont = dig;
      MODE_WORD:   cont = dig || alpha;
      default:     cont = 1'b0;
    endcase

    if (accept) begin
      if (in_end_of_input) begin
        flush = (mode_r == MODE_NUMBER) || (mode_r == MODE_WORD);
      end else begin
        flush = ((mode_r == MODE_NUMBER) || (mode_r == MODE_WORD)) && !cont;
        fresh = !cont;
      end

      // append to the running token, keep the first bytes only
      if (!in_end_of_input && cont) begin
        if (cnt_r < LEN_W'(MAX_TOKEN_BYTES)) begin
          buf_nxt[BYTE_W*cnt_r[BIDX_W-1:0] +: BYTE_W] = in_char_byte;
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          ovf_nxt = 1'b1;
        end
      end

      // hand the finished run to the back end and go idle
      if (flush) begin
        rec.has_flush   = 1'b1;
        rec.flush_word  = (mode_r == MODE_WORD);
        rec.flush_text  = buf_r;
        rec.flush_len   = cnt_r;
        rec.flush_trunc = ovf_r;
        mode_nxt = MODE_IDLE;
        buf_nxt  = '0;
        cnt_nxt  = '0;
        ovf_nxt  = 1'b0;
      end

      // byte seen with no run pending
      if (fresh) begin
        if (is_operator(in_char_byte)) begin
          rec.has_char  = 1'b1;
          rec.char_kind = KIND_OPERATOR;
          rec.char_byte = in_char_byte;
        end else if (is_separator(in_char_byte)) begin
          rec.has_char  = 1'b1;
          rec.char_kind = KIND_SEPARATOR;
          rec.char_byte = in_char_byte;
        end else if (dig || alpha) begin
          mode_nxt = dig ? MODE_NUMBER : MODE_WORD;
          buf_nxt  = {{(TEXT_W - BYTE_W){1'b0}}, in_char_byte};
          cnt_nxt  = LEN_W'(1);
          ovf_nxt  = 1'b0;
        end
      end
    end

    q_push  = rec.has_flush || rec.has_char;
    q_wdata = rec;
  end

  // scan state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      buf_r  <= '0;
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      buf_r  <= buf_nxt;
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  // checks
  `CTC_ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= LEN_W'(MAX_TOKEN_BYTES), "run too long")
  `CTC_ASSERT_IMPL(a_idle_empty, clk, rst_n, mode_r == MODE_IDLE, (cnt_r == '0) && !ovf_r, "idle with data")
  `CTC_ASSERT_IMPL(a_push_on_accept, clk, rst_n, q_push, accept && !q_full, "queue write without item")

endmodule

/* src/ctc_back.sv */
// ----------------------------------------------------------------------------
// ctc_back
// token back end: keyword compare, result formatting and output register
// ----------------------------------------------------------------------------
`include "c_token_classifier_top_assert.svh"

module ctc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ctc_pkg::rec_t               q_rdata,
  input  logic                        q_empty,
  output logic                        q_pop,
  output logic [ctc_pkg::KIND_W-1:0]  out_token_kind,
  output logic [ctc_pkg::TEXT_W-1:0]  out_token_text,
  output logic [ctc_pkg::LEN_W-1:0]   out_token_length,
  output logic                        out_truncated,
  output logic [ctc_pkg::KWI_W-1:0]   out_keyword_index,
  output logic                        out_last_of_run,
  output logic                        empty,
  input  logic                        pop
);
  import ctc_pkg::*;

  logic               valid_r, valid_nxt;
  logic               part_r, part_nxt;
  kind_t              kind_r, kind_nxt;
  logic [TEXT_W-1:0]  text_r, text_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               trunc_r, trunc_nxt;
  logic [KWI_W-1:0]   kwi_r, kwi_nxt;
  logic               last_r, last_nxt;
  logic               load, fire, second;
  kw_hit_t            kw;

  assign load   = !valid_r || pop;
  assign fire   = load && !q_empty;
  assign second = part_r || !q_rdata.has_flush;
  assign kw     = kw_match(q_rdata.flush_text, q_rdata.flush_len, q_rdata.flush_trunc);

  // pick the next result from the queue head
  always_comb begin
    kind_nxt  = kind_r;
    text_nxt  = text_r;
    len_nxt   = len_r;
    trunc_nxt = trunc_r;
    kwi_nxt   = kwi_r;
    last_nxt  = last_r;
    part_nxt  = part_r;
    valid_nxt = load ? 1'b0 : valid_r;
    q_pop     = 1'b0;

    if (fire) begin
      valid_nxt = 1'b1;
      if (second) begin
        kind_nxt  = q_rdata.char_kind;
        text_nxt  = {{(TEXT_W - BYTE_W){1'b0}}, q_rdata.char_byte};
        len_nxt   = LEN_W'(1);
        trunc_nxt = 1'b0;
        kwi_nxt   = '0;
        last_nxt  = 1'b1;
        part_nxt  = 1'b0;
        q_pop     = 1'b1;
      end else begin
        if (!q_rdata.flush_word) begin
          kind_nxt = KIND_NUMBER;
          kwi_nxt  = '0;
        end else if (kw.hit) begin
          kind_nxt = KIND_KEYWORD;
          kwi_nxt  = kw.idx;
        end else begin
          kind_nxt = KIND_IDENTIFIER;
          kwi_nxt  = '0;
        end
        text_nxt  = q_rdata.flush_text;
        len_nxt   = q_rdata.flush_len;
        trunc_nxt = q_rdata.flush_trunc;
        last_nxt  = !q_rdata.has_char;
        part_nxt  = q_rdata.has_char;
        q_pop     = !q_rdata.has_char;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      part_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      part_r  <= part_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    text_r  <= text_nxt;
    len_r   <= len_nxt;
    trunc_r <= trunc_nxt;
    kwi_r   <= kwi_nxt;
    last_r  <= last_nxt;
  end

  assign empty             = !valid_r;
  assign out_token_kind    = kind_r;
  assign out_token_text    = text_r;
  assign out_token_length  = len_r;
  assign out_truncated     = trunc_r;
  assign out_keyword_index = kwi_r;
  assign out_last_of_run   = last_r;

  // checks
  `CTC_ASSERT_IMPL(a_part_head, clk, rst_n, part_r, !q_empty && q_rdata.has_char, "second half lost")
  `CTC_ASSERT_IMPL(a_kw_not_trunc, clk, rst_n, valid_r && (kind_r == KIND_KEYWORD), !trunc_r, "truncated keyword")
  `CTC_ASSERT_IMPL(a_kwi_zero, clk, rst_n, valid_r && (kind_r != KIND_KEYWORD), kwi_r == '0, "stray keyword index")

endmodule

/* src/c_token_classifier_top.sv */
// ----------------------------------------------------------------------------
// c_token_classifier_top
// c lexical scanner: bytes in, classified tokens out
// ----------------------------------------------------------------------------
//  channel  | ports                                  | handshake
//  ---------+----------------------------------------+----------------------
//  input    | in_char_byte, in_end_of_input          | push / full
//  result   | out_token_kind .. out_last_of_run      | empty / pop
//
// one item is taken per cycle while the four-entry queue has room
// an item that gives two results stays at the queue head until its second result is loaded
// a result passes through a queue entry and then the output register after its item is accepted
// synchronous active-low reset empties the queue and the output register
// a stalled result side backs up through the queue to full
// ----------------------------------------------------------------------------
module c_token_classifier_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ctc_pkg::BYTE_W-1:0]  in_char_byte,
  input  logic                        in_end_of_input,
  input  logic                        push,
  output logic                        full,
  output logic [ctc_pkg::KIND_W-1:0]  out_token_kind,
  output logic [ctc_pkg::TEXT_W-1:0]  out_token_text,
  output logic [ctc_pkg::LEN_W-1:0]   out_token_length,
  output logic                        out_truncated,
  output logic [ctc_pkg::KWI_W-1:0]   out_keyword_index,
  output logic                        out_last_of_run,
  output logic                        empty,
  input  logic                        pop
);
  import ctc_pkg::*;

  logic              q_push, q_full, q_pop, q_empty;
  rec_t              q_wdata, q_rdata;

  // scanner front
  ctc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_char_byte    (in_char_byte),
    .in_end_of_input (in_end_of_input),
    .push            (push),
    .full            (full),
    .q_push          (q_push),
    .q_wdata         (q_wdata),
    .q_full          (q_full)
  );

  // work queue
  ctc_fifo u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  // token back end
  ctc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_rdata           (q_rdata),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .out_token_kind    (out_token_kind),
    .out_token_text    (out_token_text),
    .out_token_length  (out_token_length),
    .out_truncated     (out_truncated),
    .out_keyword_index (out_keyword_index),
    .out_last_of_run   (out_last_of_run),
    .empty             (empty),
    .pop               (pop)
  );

endmodule
